### rtl/xed_pkg.sv
package xed_pkg;

  localparam int MaxResults = 5;
  localparam int PendMax    = 4;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_SEEN = 4'd1,
    ST_L    = 4'd2,
    ST_LT   = 4'd3,
    ST_G    = 4'd4,
    ST_GT   = 4'd5,
    ST_A    = 4'd6,
    ST_AM   = 4'd7,
    ST_AMP  = 4'd8,
    ST_AP   = 4'd9,
    ST_APO  = 4'd10,
    ST_APOS = 4'd11,
    ST_Q    = 4'd12,
    ST_QU   = 4'd13,
    ST_QUO  = 4'd14,
    ST_QUOT = 4'd15
  } st_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
    logic                       has;
    logic                       last;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nxt;
  } edge_t;

  function automatic logic [2:0] pend_len(input st_t s);
    case (s)
      ST_L, ST_G, ST_A, ST_Q:              pend_len = 3'd1;
      ST_LT, ST_GT, ST_AM, ST_AP, ST_QU:   pend_len = 3'd2;
      ST_AMP, ST_APO, ST_QUO:              pend_len = 3'd3;
      ST_APOS, ST_QUOT:                    pend_len = 3'd4;
      default:                             pend_len = 3'd0;
    endcase
  endfunction

  function automatic logic [PendMax-1:0][7:0] pend_text(input st_t s);
    logic [PendMax-1:0][7:0] t;
    t = '0;
    case (s)
      ST_L:    t[0] = "l";
      ST_LT:   begin t[0] = "l"; t[1] = "t"; end
      ST_G:    t[0] = "g";
      ST_GT:   begin t[0] = "g"; t[1] = "t"; end
      ST_A:    t[0] = "a";
      ST_AM:   begin t[0] = "a"; t[1] = "m"; end
      ST_AMP:  begin t[0] = "a"; t[1] = "m"; t[2] = "p"; end
      ST_AP:   begin t[0] = "a"; t[1] = "p"; end
      ST_APO:  begin t[0] = "a"; t[1] = "p"; t[2] = "o"; end
      ST_APOS: begin t[0] = "a"; t[1] = "p"; t[2] = "o"; t[3] = "s"; end
      ST_Q:    t[0] = "q";
      ST_QU:   begin t[0] = "q"; t[1] = "u"; end
      ST_QUO:  begin t[0] = "q"; t[1] = "u"; t[2] = "o"; end
      ST_QUOT: begin t[0] = "q"; t[1] = "u"; t[2] = "o"; t[3] = "t"; end
      default: t = '0;
    endcase
    return t;
  endfunction

  // character for a complete name on ';', zero otherwise
  function automatic logic [7:0] term_char(input st_t s);
    case (s)
      ST_LT:   term_char = "<";
      ST_GT:   term_char = ">";
      ST_AMP:  term_char = "&";
      ST_APOS: term_char = 8'h27;
      ST_QUOT: term_char = 8'h22;
      default: term_char = 8'h00;
    endcase
  endfunction

  function automatic edge_t next_edge(input st_t s, input logic [7:0] b);
    edge_t e;
    e = '0;
    case (s)
      ST_SEEN: begin
        if (b == "l") e = '{1'b1, ST_L};
        else if (b == "g") e = '{1'b1, ST_G};
        else if (b == "a") e = '{1'b1, ST_A};
        else if (b == "q") e = '{1'b1, ST_Q};
      end
      ST_L:   if (b == "t") e = '{1'b1, ST_LT};
      ST_G:   if (b == "t") e = '{1'b1, ST_GT};
      ST_A: begin
        if (b == "m") e = '{1'b1, ST_AM};
        else if (b == "p") e = '{1'b1, ST_AP};
      end
      ST_AM:  if (b == "p") e = '{1'b1, ST_AMP};
      ST_AP:  if (b == "o") e = '{1'b1, ST_APO};
      ST_APO: if (b == "s") e = '{1'b1, ST_APOS};
      ST_Q:   if (b == "u") e = '{1'b1, ST_QU};
      ST_QU:  if (b == "o") e = '{1'b1, ST_QUO};
      ST_QUO: if (b == "t") e = '{1'b1, ST_QUOT};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

### rtl/xed_decode.sv
module xed_decode (
  input  xed_pkg::st_t  st,
  input  logic [7:0]    b,
  input  logic          last,
  output xed_pkg::st_t  st_next,
  output xed_pkg::res_t res
);
  import xed_pkg::*;

  logic [PendMax-1:0][7:0]    pend;
  logic [PendMax-1:0][7:0]    pend2;
  logic [2:0]                 plen;
  logic [7:0]                 term;
  edge_t                      e;
  st_t                        ns;
  logic [MaxResults-1:0][7:0] lst;
  logic [CntW-1:0]            n;
  logic                       has;

  always_comb begin
    pend  = pend_text(st);
    plen  = pend_len(st);
    term  = term_char(st);
    e     = next_edge(st, b);
    lst   = '0;
    n     = '0;
    ns    = st;
    has   = 1'b1;
    pend2 = '0;

    if (st == ST_IDLE) begin
      if (b == CH_AMP) begin
        ns = ST_SEEN;
      end else begin
        lst[0] = b;
        n      = CntW'(1);
      end
    end else if (term != 8'h00 && b == CH_SEMI) begin
      lst[0] = term;
      n      = CntW'(1);
      ns     = ST_IDLE;
    end else if (e.ok) begin
      ns = st_t'(e.nxt);
    end else begin
      // broken prefix: drop the ampersand, replay the letters
      for (int k = 0; k < PendMax; k++) begin
        lst[k] = pend[k];
      end
      n  = CntW'(plen);
      ns = ST_IDLE;
      if (b == CH_AMP) begin
        ns = ST_SEEN;
      end else begin
        lst[plen] = b;
        n         = CntW'(plen + 3'd1);
      end
    end

    if (last) begin
      pend2 = pend_text(ns);
      if (n == '0) begin
        for (int k = 0; k < PendMax; k++) begin
          lst[k] = pend2[k];
        end
        n = CntW'(pend_len(ns));
      end
      ns = ST_IDLE;
      if (n == '0) begin
        n   = CntW'(1);
        has = 1'b0;
      end
    end

    st_next   = ns;
    res.bytes = lst;
    res.cnt   = n;
    res.has   = has;
    res.last  = last;
  end

endmodule

### rtl/xed_queue.sv
module xed_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  xed_pkg::res_t           ld,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    has_byte,
  output logic                    run_last,
  output logic                    text_end,
  output logic [xed_pkg::CntW-1:0] cnt
);
  import xed_pkg::*;

  logic [MaxResults-1:0][7:0] bytes;
  logic                       has;
  logic                       last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= ld.cnt;
    end else if (cnt != '0 && out_ready) begin
      cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= ld.bytes;
      has   <= ld.has;
      last  <= ld.last;
    end else if (cnt != '0 && out_ready) begin
      bytes <= {8'h00, bytes[MaxResults-1:1]};
    end
  end

  assign out_valid = (cnt != '0);
  assign out_byte  = bytes[0];
  assign has_byte  = has;
  assign run_last  = (cnt == CntW'(1));
  assign text_end  = (cnt == CntW'(1)) && last;

endmodule

### rtl/xml_entity_decoder.sv
// XML predefined entity decoder.
// Input channel (in_valid/in_ready): one text byte per transaction, with
// text_last marking the final byte of a text run. Output channel
// (out_valid/out_ready): one decoded byte per transaction; has_byte low
// marks a bare end of run, run_last flags the last result of an input
// transaction and text_end the last result of the run.
// The input register holds a taken byte, which is then decoded into the
// result register.
// One input byte per cycle while each byte gives at most one result and
// the receiver is ready. An input that gives more than one result (entity
// prefix replayed, or a flush at the end of a run) holds the result
// register until all are taken; a byte that extends an entity prefix
// gives none. The input register takes a further transaction while
// results wait. Reset clears the match state and empties both registers.
// When the receiver stalls the result register holds, then the input
// register fills and in_ready falls.
module xml_entity_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       text_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       run_last,
  output logic       text_end
);
  import xed_pkg::*;

  logic            inv;
  logic [7:0]      ib;
  logic            il;
  st_t             st;
  st_t             st_next;
  res_t            res;
  logic [CntW-1:0] q_cnt;
  logic            adv;

  assign adv      = inv && (q_cnt == '0 || (q_cnt == CntW'(1) && out_ready));
  assign in_ready = !inv || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv <= 1'b0;
    end else if (in_valid && in_ready) begin
      inv <= 1'b1;
    end else if (adv) begin
      inv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib <= in_byte;
      il <= text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else if (adv) begin
      st <= st_next;
    end
  end

  xed_decode u_decode (
    .st      (st),
    .b       (ib),
    .last    (il),
    .st_next (st_next),
    .res     (res)
  );

  xed_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (adv),
    .ld        (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .run_last  (run_last),
    .text_end  (text_end),
    .cnt       (q_cnt)
  );

  a_marker_ends : assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_byte |-> run_last && text_end)
    else $error("bare end marker not flagged as last");

  a_run_end_idle : assert property (@(posedge clk) disable iff (rst)
    adv && il |=> st == ST_IDLE)
    else $error("match state not idle after end of run");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    out_ready && q_cnt > CntW'(1) |=> q_cnt == $past(q_cnt) - CntW'(1))
    else $error("result register did not drain by one");

  a_cnt_range : assert property (@(posedge clk) disable iff (rst)
    q_cnt <= CntW'(MaxResults))
    else $error("result count out of range");

endmodule
